// ===== sv/serial_line_assembler_defines.svh =====
// ----------------------------------------------------------------------------
// serial_line_assembler_defines
// Assertion macros used by the serial line assembler RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_ASSEMBLER_DEFINES_SVH
`define SERIAL_LINE_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset
`define SLA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("serial_line_assembler: same-cycle check failed");

// Next-cycle implication, checked at every clock edge out of reset
`define SLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("serial_line_assembler: next-cycle check failed");

`endif

// ===== sv/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg
// Constants, codes and control/status types of the serial line assembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sla_pkg;

  // Line buffer size in characters, including room for the terminator
  localparam int LINE_BUFFER_SIZE = 32;
  // Characters a line can actually hold
  localparam int STORE_DEPTH      = LINE_BUFFER_SIZE - 1;
  // Fill count holds 0 .. STORE_DEPTH
  localparam int FILL_W           = $clog2(LINE_BUFFER_SIZE);
  // Index into the line store
  localparam int IDX_W            = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Special characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // Result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // Source of the next result item
  typedef enum logic [1:0] {
    SEL_ECHO = 2'd0,
    SEL_LF   = 2'd1,
    SEL_LINE = 2'd2
  } sla_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;      // take the input item and update line state
    logic     load_out;    // load one result into the output register
    sla_sel_e out_sel;     // which result to load
    logic     out_last;    // result is the last one of this item
    logic     rd_advance;  // step the line readout pointer
  } sla_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic plan_echo;  // echo is enabled for an item accepted now
    logic plan_emit;  // an item accepted now completes a line
    logic byte_cr;    // the held item is CR
    logic emit;       // the held item completed a line
    logic rd_last;    // readout pointer sits on the last line character
    logic out_free;   // output register can take a result this cycle
  } sla_sts_t;

endpackage

// ===== sv/sla_dp.sv =====
// ----------------------------------------------------------------------------
// sla_dp
// Datapath: echo register, line store, fill count, CR flag, line readout
// pointer and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sla_dp import sla_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             out_stall_i,
  input  sla_cmd_t         cmd_i,
  output sla_sts_t         sts_o,
  output logic             out_valid_o,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic             run_last_o
);

  logic              echo_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              cr_q;
  logic [7:0]        byte_q;
  logic              byte_cr_q;
  logic              emit_q;
  logic [FILL_W-1:0] len_q;
  logic [FILL_W-1:0] rd_cnt_q, rd_cnt_inc;
  logic [7:0]        rdata_q;
  logic [7:0]        line_mem_q [STORE_DEPTH];
  logic              out_valid_q;
  logic              out_kind_q, out_kind_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_last_q;

  logic is_cr, is_lf, is_erase, fill_nz, fill_full, emit_now, do_store;

  // Decode the incoming character against the current line state
  assign is_cr     = (rx_byte_i == CH_CR);
  assign is_lf     = (rx_byte_i == CH_LF);
  assign is_erase  = (rx_byte_i == CH_BS) || (rx_byte_i == CH_DEL);
  assign fill_nz   = (fill_q != '0);
  assign fill_full = (fill_q >= FILL_W'(STORE_DEPTH));
  assign emit_now  = fill_nz && (is_cr || (is_lf && !cr_q));
  assign do_store  = !is_cr && !is_lf && !is_erase && !fill_full;

  // Next fill count: clear on line end or overflow, drop on erase, grow on store
  always_comb begin
    fill_d = fill_q;
    if (emit_now) begin
      fill_d = '0;
    end else if (is_cr || is_lf) begin
      fill_d = fill_q;
    end else if (is_erase) begin
      if (fill_nz) begin
        fill_d = fill_q - FILL_W'(1);
      end
    end else if (!fill_full) begin
      fill_d = fill_q + FILL_W'(1);
    end else begin
      fill_d = '0;
    end
  end

  assign rd_cnt_inc = rd_cnt_q + FILL_W'(1);

  // Select the result to load
  always_comb begin
    case (cmd_i.out_sel)
      SEL_ECHO: begin
        out_kind_d = KIND_ECHO;
        out_data_d = byte_q;
      end
      SEL_LF: begin
        out_kind_d = KIND_ECHO;
        out_data_d = CH_LF;
      end
      SEL_LINE: begin
        out_kind_d = KIND_LINE;
        out_data_d = rdata_q;
      end
      default: begin
        out_kind_d = KIND_ECHO;
        out_data_d = byte_q;
      end
    endcase
  end

  // Control state: echo enable, line state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q      <= 1'b1;
      fill_q      <= '0;
      cr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        echo_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        fill_q <= fill_d;
        cr_q   <= is_cr;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted item and the line length, step the readout pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q    <= rx_byte_i;
      byte_cr_q <= is_cr;
      emit_q    <= emit_now;
      len_q     <= fill_q;
      rd_cnt_q  <= '0;
    end else if (cmd_i.rd_advance) begin
      rd_cnt_q  <= rd_cnt_inc;
    end
    if (cmd_i.load_out) begin
      out_kind_q <= out_kind_d;
      out_data_q <= out_data_d;
      out_last_q <= cmd_i.out_last;
    end
  end

  // Line store: write on append, registered read at the readout pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && do_store) begin
      line_mem_q[fill_q[IDX_W-1:0]] <= rx_byte_i;
    end
    rdata_q <= line_mem_q[rd_cnt_q[IDX_W-1:0]];
  end

  assign sts_o.plan_echo = echo_q;
  assign sts_o.plan_emit = emit_now;
  assign sts_o.byte_cr   = byte_cr_q;
  assign sts_o.emit      = emit_q;
  assign sts_o.rd_last   = (rd_cnt_inc == len_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign data_byte_o = out_data_q;
  assign run_last_o  = out_last_q;

endmodule

// ===== sv/sla_ctrl.sv =====
// ----------------------------------------------------------------------------
// sla_ctrl
// Controller: sequences the echo results and the line readout of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sla_ctrl import sla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  sla_sts_t sts_i,
  output sla_cmd_t cmd_o,
  output logic     idle_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_ECHO     = 5'b00010,
    ST_ECHO_LF  = 5'b00100,
    ST_LINE_RD  = 5'b01000,
    ST_LINE_OUT = 5'b10000
  } sla_state_e;

  sla_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.plan_echo) begin
            state_d = ST_ECHO;
          end else if (sts_i.plan_emit) begin
            state_d = ST_LINE_RD;
          end
        end
      end
      ST_ECHO: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = SEL_ECHO;
          cmd_o.out_last = !sts_i.byte_cr && !sts_i.emit;
          if (sts_i.byte_cr) begin
            state_d = ST_ECHO_LF;
          end else if (sts_i.emit) begin
            state_d = ST_LINE_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ECHO_LF: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_sel  = SEL_LF;
          cmd_o.out_last = !sts_i.emit;
          state_d        = sts_i.emit ? ST_LINE_RD : ST_IDLE;
        end
      end
      ST_LINE_RD: begin
        // wait for the registered store read
        state_d = ST_LINE_OUT;
      end
      ST_LINE_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.out_sel    = SEL_LINE;
          cmd_o.out_last   = sts_i.rd_last;
          cmd_o.rd_advance = 1'b1;
          state_d          = sts_i.rd_last ? ST_IDLE : ST_LINE_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

// ===== sv/serial_line_assembler.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler
// Line editor for a received serial byte stream with optional echo.
// ----------------------------------------------------------------------------
// One item is processed at a time. An accepted item yields its echo results
// (the byte, plus LF after a CR) when echo is on and, if it completes a line,
// the characters of that line; each line character is first read from the
// line store, a memory with a registered read port, and then loaded into the
// output register. A result is loaded only while the output register is free.
// The output register lets the next item be accepted while the last result of
// the previous one still waits.
`timescale 1ns / 1ps
`include "serial_line_assembler_defines.svh"

module serial_line_assembler import sla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] data_byte_o,
  output logic       run_last_o
);

  sla_cmd_t cmd;
  sla_sts_t sts;
  logic     idle;

  // Sequence results of one item
  sla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  // Line state, store and output register
  sla_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_byte_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .run_last_o  (run_last_o)
  );

  assign in_stall_o = !idle;

  // An item with results keeps the input stalled while they are produced
  `SLA_ASSERT_NEXT(a_busy_after_accept, cmd.accept && (sts.plan_echo || sts.plan_emit), in_stall_o)
  // The last result of an item frees the input in the next cycle
  `SLA_ASSERT_NEXT(a_idle_after_last, cmd.load_out && cmd.out_last, !in_stall_o)
  // Never overwrite a result that is still waiting
  `SLA_ASSERT_IMP(a_load_when_free, cmd.load_out, sts.out_free)

endmodule
